@@ hdl/tcw_pkg.sv @@
// Shared types, field widths and codes for the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // attribute 0x00, space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0000;

    typedef enum logic [OP_W-1:0] {
        OP_PUT     = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
        logic [IDX_W-1:0]  cell_index;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_line;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

@@ hdl/tcw_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
interface tcw_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: sequencer, cell RAM and result register.
//
// Text-mode screen writer holding ROWS x COLUMNS 16-bit cells (attribute in the
// high byte, character in the low byte) plus a cursor. Each command beat on cmd
// gives exactly one result beat on rsp, in order, carrying the cursor after the
// command and, for a read, the cell (zero for any other command or for a cell
// number past the end of the screen). A command passes from acceptance through a
// done state into the result register. A put that wraps past the last row, or a
// newline on the last row, scrolls the screen: the copy sweep moves one cell a
// cycle through the single write and read port of the cell RAM, and then the
// bottom row is blanked. After reset the RAM is swept to zero, one cell a
// cycle; cmd.ready stays low until it finishes. A new command is taken while
// the previous result still waits in the output register; the sequencer only
// stalls when its own result cannot be loaded.
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic         clk,
    input  logic         rst_n,
    tcw_stream_if.sink   cmd,
    tcw_stream_if.source rsp
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // sequencer to result register
    logic              done_valid;
    logic              done_ready;
    rsp_t              done;

    // cell RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg;
    logic              load;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .cmd        (cmd.payload),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done       (done),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // slot is free when empty or its beat leaves this cycle
    assign done_ready = !rsp_valid_reg || rsp.ready;
    assign load       = done_valid && done_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_data_reg <= done;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule

@@ hdl/tcw_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/tcw_ctrl.sv @@
// Sequencer: cursor, command decode, clear pass and scroll sweep over the cell RAM.
module tcw_ctrl import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  cmd_t                                cmd,
    output logic                                done_valid,
    input  logic                                done_ready,
    output rsp_t                                done,
    output logic                                wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     wr_addr,
    output logic [CELL_W-1:0]                   wr_data,
    output logic                                rd_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     rd_addr,
    input  logic [CELL_W-1:0]                   rd_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CMP_W      = ((ADDR_W >= IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [CMP_W-1:0]  CELL_LIMIT = CMP_W'(CELL_COUNT);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               pend_reg, pend_next;
    logic               rd_sel_reg, rd_sel_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic [ADDR_W-1:0]  cnt_step;
    logic [ADDR_W-1:0]  cursor_addr;
    logic               line_end;
    logic               in_range;

    assign cnt_step    = cnt_reg + ADDR_W'(1);
    assign cursor_addr = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);
    assign line_end    = (cmd.op == OP_NEWLINE) || ((cmd.op == OP_PUT) && (col_reg == COL_LAST));
    assign in_range    = CMP_W'(cmd.cell_index) < CELL_LIMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_addr_reg <= '0;
            pend_reg      <= 1'b0;
            rd_sel_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_addr_reg <= pend_addr_next;
            pend_reg      <= pend_next;
            rd_sel_reg    <= rd_sel_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = 1'b0;
        rd_sel_next    = rd_sel_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = CLEAR_CELL;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg + ROW_STRIDE;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_step;
                end
            end

            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    rd_sel_next = 1'b0;
                    state_next  = ST_DONE;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = cursor_addr;
                            wr_data  = {cmd.attribute, cmd.char_code};
                            col_next = col_reg + COL_W'(1);
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = ADDR_W'(cmd.cell_index);
                                rd_sel_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (line_end)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_LAST)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                end
            end

            // copy cell i+COLUMNS to cell i; each write follows its read in the next cycle
            ST_SCROLL:
            begin
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg;
                wr_data = rd_data;
                if (cnt_reg == SCROLL_END)
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg;
                    cnt_next       = cnt_step;
                end
            end

            ST_BLANK:
            begin
                wr_en   = 1'b1;
                wr_data = BLANK_CELL;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_step;
                end
            end

            ST_DONE:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_valid         = (state_reg == ST_DONE);
    assign done.cell_data     = rd_sel_reg ? rd_data : CLEAR_CELL;
    assign done.cursor_column = col_reg;
    assign done.cursor_line   = row_reg;

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [CELL_W-1:0] cell_data,
    input logic [COL_W-1:0]  cursor_column,
    input logic [ROW_W-1:0]  cursor_line
);

    // beats accepted on cmd and not yet answered on rsp
    logic [1:0] owed_reg, owed_next;

    always_comb
    begin
        owed_next = owed_reg;
        if ((cmd_valid && cmd_ready) && !(rsp_valid && rsp_ready))
        begin
            owed_next = owed_reg + 2'd1;
        end
        else if (!(cmd_valid && cmd_ready) && (rsp_valid && rsp_ready))
        begin
            owed_next = owed_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_data)
            && $stable(cursor_column) && $stable(cursor_line))
        else $error("result beat changed while stalled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(cursor_column) < COLUMNS) && (32'(cursor_line) < ROWS))
        else $error("cursor outside the screen");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> owed_reg != 2'd0)
        else $error("result beat without a command");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg != 2'd3)
        else $error("more than two commands outstanding");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .cell_data     (rsp.payload.cell_data),
    .cursor_column (rsp.payload.cursor_column),
    .cursor_line   (rsp.payload.cursor_line)
);

@@ tb/sv/tcw_screen_checker.sv @@
// Screen and cursor predictor with an in-order response scoreboard for the console writer.
module tcw_screen_checker import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd_beat,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_beat,
    output int   fail_count,
    output int   pending,
    output int   put_count,
    output int   newline_count,
    output int   read_count,
    output int   read_miss_count,
    output int   nop_count,
    output int   scroll_count,
    output int   wrap_scroll_count
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [CELL_W-1:0] screen [CELLS];
    int                col_now;
    int                row_now;
    rsp_t              due_rsp [$];
    rsp_t              want;

    // cursor to column 0 of the next row; scrolls when it runs off the bottom
    function automatic bit advance_row();
        col_now = 0;
        row_now++;
        if (row_now < ROWS)
            return 1'b0;
        for (int i = 0; i + COLUMNS < CELLS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = BLANK_CELL;
        row_now = ROWS - 1;
        scroll_count++;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_rsp(cmd_t c);
        rsp_t              r;
        logic [CELL_W-1:0] data;
        data = CLEAR_CELL;
        case (c.op)
            OP_PUT:
            begin
                put_count++;
                screen[row_now * COLUMNS + col_now] = {c.attribute, c.char_code};
                col_now++;
                if (col_now >= COLUMNS)
                begin
                    if (advance_row())
                        wrap_scroll_count++;
                end
            end
            OP_NEWLINE:
            begin
                newline_count++;
                void'(advance_row());
            end
            OP_READ:
            begin
                read_count++;
                if (c.cell_index < CELLS)
                    data = screen[c.cell_index];
                else
                    read_miss_count++;
            end
            default:
                nop_count++;
        endcase
        r.cell_data     = data;
        r.cursor_column = COL_W'(col_now);
        r.cursor_line   = ROW_W'(row_now);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (screen[i])
                screen[i] = CLEAR_CELL;
            col_now           = 0;
            row_now           = 0;
            due_rsp.delete();
            fail_count        = 0;
            pending           = 0;
            put_count         = 0;
            newline_count     = 0;
            read_count        = 0;
            read_miss_count   = 0;
            nop_count         = 0;
            scroll_count      = 0;
            wrap_scroll_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response beat %h with no command outstanding", rsp_beat);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp_beat.cell_data !== want.cell_data)
                    begin
                        $error("cell_data expected %h, got %h",
                               want.cell_data, rsp_beat.cell_data);
                        fail_count++;
                    end
                    if (rsp_beat.cursor_column !== want.cursor_column)
                    begin
                        $error("cursor_column expected %0d, got %0d",
                               want.cursor_column, rsp_beat.cursor_column);
                        fail_count++;
                    end
                    if (rsp_beat.cursor_line !== want.cursor_line)
                    begin
                        $error("cursor_line expected %0d, got %0d",
                               want.cursor_line, rsp_beat.cursor_line);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                due_rsp.push_back(predict_rsp(cmd_beat));
            pending = due_rsp.size();
        end
    end

endmodule

@@ tb/sv/tb_text_console_writer_top.sv @@
// Testbench top for the text console writer: clock, reset, command stimulus and verdict.
module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int TOTAL_CMDS  = 1350;
    // even a run made only of scrolls would sit well inside this budget
    localparam int CYCLE_LIMIT = 15_000_000;
    localparam int IDLE_PCT    = 9;
    localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch, cycles
    localparam int HOLD_AT     = 300;   // command count that triggers the hold
    localparam int DRAIN_AT    = 700;   // command count at which the sender drains
    localparam int CALM_FROM   = 900;   // no idling on either side in this window
    localparam int CALM_TO     = 1100;
    localparam int SETTLE      = 10;    // cycles after the last response

    logic clk = 1'b0;
    logic rst_n;

    tcw_stream_if #(.payload_t(cmd_t)) cmd ();
    tcw_stream_if #(.payload_t(rsp_t)) rsp ();

    int fails;
    int pending;
    int put_count;
    int newline_count;
    int read_count;
    int read_miss_count;
    int nop_count;
    int scroll_count;
    int wrap_scroll_count;

    int sent = 0;      // accepted command beats
    bit calm = 1'b0;   // both sides stop idling while set
    bit hold_req = 1'b0;

    always #2 clk = ~clk;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    tcw_screen_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) screen_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd.valid),
        .cmd_ready         (cmd.ready),
        .cmd_beat          (cmd.payload),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_beat          (rsp.payload),
        .fail_count        (fails),
        .pending           (pending),
        .put_count         (put_count),
        .newline_count     (newline_count),
        .read_count        (read_count),
        .read_miss_count   (read_miss_count),
        .nop_count         (nop_count),
        .scroll_count      (scroll_count),
        .wrap_scroll_count (wrap_scroll_count)
    );

    // Offer one command beat and hold it until accepted. Entered and left on
    // a falling edge, so valid gets exactly one update per step: a back-to-back
    // beat simply keeps valid high with the new payload.
    task automatic send_cmd(input op_t op, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] at, input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.payload <= '{op: op, char_code: ch, attribute: at, cell_index: idx};
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Unused fields carry random bits so that every field toggles on every op.
    task automatic put_random();
        send_cmd(OP_PUT, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                 IDX_W'($urandom_range(2047)));
    endtask

    task automatic newline_random();
        send_cmd(OP_NEWLINE, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                 IDX_W'($urandom_range(2047)));
    endtask

    task automatic read_cell(input int idx);
        send_cmd(OP_READ, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                 IDX_W'(idx));
    endtask

    // Receiver: random stalls, one long hold on request, none while calm.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Cycle budget; a hang or a lost response ends here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int  pick;
        int  len;
        int  sel;
        int  idx;
        bit  hold_done;
        bit  drain_done;

        hold_done   = 1'b0;
        drain_done  = 1'b0;
        rst_n       = 1'b0;
        cmd.valid   = 1'b0;
        cmd.payload = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // The RAM clear pass keeps cmd.ready low for a while; send_cmd waits it out.
        read_cell(0);                              // cleared store reads zero
        read_cell(CELLS - 1);
        send_cmd(OP_PUT, 8'h00, 8'h00, 11'h000);   // field minimums
        send_cmd(OP_PUT, 8'hFF, 8'hFF, 11'h7FF);   // field maximums
        send_cmd(OP_PUT, 8'h55, 8'hAA, 11'h555);
        send_cmd(OP_PUT, 8'hAA, 8'h55, 11'h2AA);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(3);
        read_cell(CELLS);                          // first index past the screen
        read_cell(2047);                           // all-ones index, also past the end
        send_cmd(OP_NOP, 8'hFF, 8'hFF, 11'h7FF);   // unused code: nothing moves
        send_cmd(OP_NOP, 8'h00, 8'h00, 11'h000);
        send_cmd(OP_NEWLINE, 8'h00, 8'h00, 11'h000);
        send_cmd(OP_NEWLINE, 8'hFF, 8'hFF, 11'h7FF);
        send_cmd(OP_PUT, 8'h41, 8'h07, 11'h000);
        read_cell(2 * COLUMNS);
        read_cell(2 * COLUMNS + 1);                // not yet written
        newline_random();

        // ---- wrap past the bottom ----
        // ROWS newlines put the cursor on the last row from anywhere; a full
        // line of text then wraps off the end and must scroll like a newline.
        repeat (ROWS) newline_random();
        repeat (COLUMNS) put_random();
        read_cell((ROWS - 2) * COLUMNS);
        read_cell((ROWS - 1) * COLUMNS - 1);
        read_cell((ROWS - 1) * COLUMNS);           // fresh blank row after the scroll
        read_cell(CELLS - 1);

        // ---- random part: mostly lines of text and read-backs ----
        while (sent < TOTAL_CMDS)
        begin
            if (!hold_done && sent >= HOLD_AT)
            begin
                // receiver stops for a long stretch; we keep offering so the
                // result register fills and cmd.ready drops
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && sent >= DRAIN_AT)
            begin
                // pause until every outstanding response has come back
                drain_done = 1'b1;
                cmd.valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            calm = (sent >= CALM_FROM) && (sent < CALM_TO);

            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // a run of text, now and then long enough to wrap a line
                len = ($urandom_range(3) == 0) ? $urandom_range(100, 60)
                                               : $urandom_range(20, 1);
                repeat (len) put_random();
                if ($urandom_range(9) < 7)
                    newline_random();
            end
            else if (pick < 75)
            begin
                // read-back burst: most in range, some near the bottom, a few past the end
                repeat ($urandom_range(8, 1))
                begin
                    sel = $urandom_range(9);
                    if (sel < 8)
                        idx = $urandom_range(CELLS - 1);
                    else if (sel == 8)
                        idx = $urandom_range(CELLS - 1, CELLS - 2 * COLUMNS);
                    else
                        idx = $urandom_range(2047, CELLS);
                    read_cell(idx);
                end
            end
            else if (pick < 90)
                newline_random();
            else if (pick < 95)
                send_cmd(OP_NOP, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                         IDX_W'($urandom_range(2047)));
            else
            begin
                // noise: any code with any fields
                repeat ($urandom_range(4, 1))
                    send_cmd(op_t'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                             ATTR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
            end
        end
        calm = 1'b0;
        cmd.valid <= 1'b0;

        // drain, then let the block settle before the verdict
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d commands: %0d puts, %0d newlines,",
                 sent, put_count, newline_count,
                 " %0d reads (%0d off screen), %0d unused codes.",
                 read_count, read_miss_count, nop_count);
        $display("Screen scrolled %0d times, %0d of them from a line wrapping off the bottom.",
                 scroll_count, wrap_scroll_count);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
